FILE: rtl/arvs_pkg.sv
package arvs_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_IN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE      = 2'd3;

	localparam logic [7:0]  BLOCK_IN_RST  = 8'd128;
	localparam logic [7:0]  BLOCK_OUT_RST = 8'd128;
	localparam logic [15:0] GAIN_RST      = 16'd256;
	localparam logic [7:0]  BLOCK_IN_MAX  = 8'd128;

	localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
	localparam logic [32:0] SAT_LIMIT  = 33'd8388352;
	localparam logic [32:0] ROUND_HALF = 33'd128;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_RD_LO = 7'b0000100,
		ST_RD_HI = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_RND   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} fifo_ctl_t;

	typedef struct packed {
		logic mul_en;
		logic rnd_en;
	} scl_ctl_t;

	function automatic logic [7:0] eff_in_size(input logic [7:0] v);
		logic [7:0] r;
		begin
			r = v;
			if (v == 8'd0) begin
				r = 8'd1;
			end else if (v > BLOCK_IN_MAX) begin
				r = BLOCK_IN_MAX;
			end
			return r;
		end
	endfunction

	function automatic logic [7:0] eff_out_size(input logic [7:0] v, input logic [7:0] lim);
		logic [7:0] n;
		begin
			n = (v > lim) ? lim : v;
			n = {n[7:1], 1'b0};
			if (n < 8'd2) begin
				n = 8'd2;
			end
			return n;
		end
	endfunction

endpackage

FILE: rtl/arvs_byte_fifo.sv
module arvs_byte_fifo #(
	parameter int unsigned BUF_BYTES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  arvs_pkg::fifo_ctl_t              ctl,
	input  logic [7:0]                       wr_data,
	output logic [7:0]                       rd_data,
	output logic [$clog2(BUF_BYTES+1)-1:0]   fill
);

	localparam int unsigned AW = $clog2(BUF_BYTES);
	localparam int unsigned FW = $clog2(BUF_BYTES + 1);
	localparam logic [AW-1:0] IDX_LAST = AW'(BUF_BYTES - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(BUF_BYTES);

	logic [7:0]    mem [BUF_BYTES];
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    rd_data_q;
	logic          wr_ok;

	assign wr_ok = ctl.wr_en && (fill_q != FILL_FULL);
	assign rd_data = rd_data_q;
	assign fill = fill_q;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_idx_q] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q <= '0;
		end else begin
			if (wr_ok) begin
				wr_idx_q <= (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + AW'(1);
			end
			if (ctl.rd_en) begin
				rd_idx_q <= (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + AW'(1);
			end
			case ({wr_ok, ctl.rd_en})
				2'b10: begin
					fill_q <= fill_q + FW'(1);
				end
				2'b01: begin
					fill_q <= fill_q - FW'(1);
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

endmodule

FILE: rtl/arvs_scale.sv
module arvs_scale (
	input  logic                clk,
	input  arvs_pkg::scl_ctl_t  ctl,
	input  logic signed [15:0]  smp,
	input  logic [15:0]         gain,
	output logic signed [15:0]  result
);

	logic signed [32:0] smp_x;
	logic signed [32:0] gain_x;
	logic signed [32:0] prod_s1;
	logic signed [15:0] smp_s1;
	logic               byp_s1;
	logic               neg;
	logic [32:0]        mag;
	logic [32:0]        sum;
	logic [15:0]        r_mag;
	logic signed [15:0] rnd;
	logic signed [15:0] result_q;

	assign smp_x = 33'(smp);
	assign gain_x = $signed({17'd0, gain});

	// sign-magnitude round half away from zero, clamp to +-32767
	assign neg = prod_s1[32];
	assign mag = neg ? 33'(-prod_s1) : 33'(prod_s1);
	assign sum = mag + arvs_pkg::ROUND_HALF;
	assign r_mag = (mag > arvs_pkg::SAT_LIMIT) ? 16'(arvs_pkg::SAMPLE_MAX) : sum[23:8];
	assign rnd = neg ? -$signed(r_mag) : $signed(r_mag);
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= smp_x * gain_x;
			smp_s1 <= smp;
			byp_s1 <= (gain == 16'd0);
		end
		if (ctl.rnd_en) begin
			result_q <= byp_s1 ? smp_s1 : rnd;
		end
	end

endmodule

FILE: rtl/audio_reblock_volume_scaler_unit.sv
// The request that completes an input block with a full output block buffered runs the
// check, read-low, read-high, multiply and round states, then the first sample is offered;
// later samples repeat read-low to round. Throughput: one byte a cycle while idle; a
// completed input block passes the check state, and a popped block holds in_ready low
// until its last sample is taken (rounded, when muted). Reset (arst_n, async, active low)
// resets indices, counts, sequencer and config; store and data path need no clearing pass.
module audio_reblock_volume_scaler_unit #(
	parameter int unsigned BUF_BYTES = 256,
	parameter int unsigned MAX_OUT_BYTES = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           data_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [15:0]                   sample,
	output logic                                 last_sample,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [arvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [arvs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned FW = $clog2(BUF_BYTES + 1);
	localparam logic [7:0] OUT_LIM = 8'(MAX_OUT_BYTES);

	arvs_pkg::state_t    state_q;
	arvs_pkg::fifo_ctl_t fifo_ctl;
	arvs_pkg::scl_ctl_t  scl_ctl;

	logic [7:0]    block_in_q;
	logic [7:0]    block_out_q;
	logic [15:0]   gain_q;
	logic          mute_q;
	logic [6:0]    in_cnt_q;
	logic [6:0]    samp_left_q;
	logic [7:0]    lo_q;
	logic [7:0]    rd_data;
	logic [FW-1:0] fill;
	logic [7:0]    cnt_inc;
	logic          blk_done;
	logic [7:0]    eff_out;
	logic          in_acc;
	logic          cfg_acc;

	assign in_ready = (state_q == arvs_pkg::ST_IDLE);
	assign cfg_ready = (state_q == arvs_pkg::ST_IDLE);
	assign out_valid = (state_q == arvs_pkg::ST_OUT);
	assign last_sample = (samp_left_q == 7'd0);
	assign in_acc = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;

	assign cnt_inc = {1'b0, in_cnt_q} + 8'd1;
	assign blk_done = (cnt_inc >= arvs_pkg::eff_in_size(block_in_q));
	assign eff_out = arvs_pkg::eff_out_size(block_out_q, OUT_LIM);

	assign fifo_ctl.wr_en = in_acc;
	assign fifo_ctl.rd_en = (state_q == arvs_pkg::ST_RD_LO) || (state_q == arvs_pkg::ST_RD_HI);
	assign scl_ctl.mul_en = (state_q == arvs_pkg::ST_MUL);
	assign scl_ctl.rnd_en = (state_q == arvs_pkg::ST_RND);

	arvs_byte_fifo #(
		.BUF_BYTES(BUF_BYTES)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(fifo_ctl),
		.wr_data(data_byte),
		.rd_data(rd_data),
		.fill(fill)
	);

	arvs_scale u_scale (
		.clk(clk),
		.ctl(scl_ctl),
		.smp($signed({rd_data, lo_q})),
		.gain(gain_q),
		.result(sample)
	);

	always_ff @(posedge clk) begin
		if (state_q == arvs_pkg::ST_RD_HI) begin
			lo_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_in_q <= arvs_pkg::BLOCK_IN_RST;
			block_out_q <= arvs_pkg::BLOCK_OUT_RST;
			gain_q <= arvs_pkg::GAIN_RST;
			mute_q <= 1'b0;
		end else if (cfg_acc) begin
			case (cfg_index)
				arvs_pkg::CFG_BLOCK_IN: begin
					block_in_q <= cfg_data[7:0];
				end
				arvs_pkg::CFG_BLOCK_OUT: begin
					block_out_q <= cfg_data[7:0];
				end
				arvs_pkg::CFG_GAIN: begin
					gain_q <= cfg_data;
				end
				arvs_pkg::CFG_MUTE: begin
					mute_q <= cfg_data[0];
				end
				default: begin
					mute_q <= mute_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arvs_pkg::ST_IDLE;
			in_cnt_q <= '0;
			samp_left_q <= '0;
		end else begin
			case (state_q)
				arvs_pkg::ST_IDLE: begin
					if (in_acc) begin
						in_cnt_q <= blk_done ? 7'd0 : cnt_inc[6:0];
						if (blk_done) begin
							state_q <= arvs_pkg::ST_CHECK;
						end
					end
				end
				arvs_pkg::ST_CHECK: begin
					samp_left_q <= eff_out[7:1];
					state_q <= (fill >= FW'(eff_out)) ? arvs_pkg::ST_RD_LO : arvs_pkg::ST_IDLE;
				end
				arvs_pkg::ST_RD_LO: begin
					samp_left_q <= samp_left_q - 7'd1;
					state_q <= arvs_pkg::ST_RD_HI;
				end
				arvs_pkg::ST_RD_HI: begin
					state_q <= arvs_pkg::ST_MUL;
				end
				arvs_pkg::ST_MUL: begin
					state_q <= arvs_pkg::ST_RND;
				end
				arvs_pkg::ST_RND: begin
					if (!mute_q) begin
						state_q <= arvs_pkg::ST_OUT;
					end else if (samp_left_q == 7'd0) begin
						state_q <= arvs_pkg::ST_IDLE;
					end else begin
						state_q <= arvs_pkg::ST_RD_LO;
					end
				end
				arvs_pkg::ST_OUT: begin
					if (out_ready) begin
						state_q <= (samp_left_q == 7'd0) ? arvs_pkg::ST_IDLE
							: arvs_pkg::ST_RD_LO;
					end
				end
				default: begin
					state_q <= arvs_pkg::ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a sample is pending");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FW'(BUF_BYTES))
		else $error("fill count beyond store size");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arvs_pkg::ST_RD_LO) |-> (fill >= FW'(2)))
		else $error("sample read with fewer than two bytes buffered");

	a_last_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_sample) |=> in_ready)
		else $error("block did not end on last sample");
`endif

endmodule

FILE: tb/tb_audio_reblock_volume_scaler_unit.sv
`timescale 1ns / 100ps

module tb_audio_reblock_volume_scaler_unit;

	localparam int unsigned STORE_DEPTH = 256;
	localparam int unsigned OUT_MAX = 128;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int          RND_PHASES = 6;

	typedef struct packed {
		logic signed [15:0] smp;
		logic               last;
	} sample_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [7:0]                      data_byte = 8'd0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic signed [15:0]              sample;
	logic                            last_sample;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [arvs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [arvs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expected output
	logic [7:0] pending_bytes[$];
	sample_t    due_samples[$];

	// predictor state
	logic [7:0]  byte_fifo[STORE_DEPTH];
	int unsigned wr_ptr = 0;
	int unsigned rd_ptr = 0;
	int unsigned fifo_level = 0;
	int unsigned blk_fill = 0;
	logic [7:0]  set_in = arvs_pkg::BLOCK_IN_RST;
	logic [7:0]  set_out = arvs_pkg::BLOCK_OUT_RST;
	logic [15:0] set_gain = arvs_pkg::GAIN_RST;
	logic        set_mute = 1'b0;

	int unsigned cycles = 0;
	int unsigned errors = 0;
	bit          in_took = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	bit          hold_req = 1'b0;
	int          hold_cnt = 0;

	audio_reblock_volume_scaler_unit #(
		.BUF_BYTES(STORE_DEPTH),
		.MAX_OUT_BYTES(OUT_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.last_sample(last_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [15:0] scale_sample(input logic signed [15:0] s,
			input logic [15:0] g);
		longint prod;
		longint mag;
		longint res;
		if (g == 16'd0) begin
			return s;
		end
		prod = longint'(s) * longint'(g);
		mag = (prod < 0) ? -prod : prod;
		if (mag > longint'(arvs_pkg::SAMPLE_MAX) * 256) begin
			res = longint'(arvs_pkg::SAMPLE_MAX);
		end else begin
			res = (mag + 128) >>> 8;
		end
		if (prod < 0) begin
			res = -res;
		end
		return res[15:0];
	endfunction

	// one byte in; pushes the samples of any popped output block unless muted
	function automatic void stash_byte(input logic [7:0] b);
		int unsigned need_in;
		int unsigned need_out;
		int unsigned nsamp;
		logic [7:0]  lo;
		logic [7:0]  hi;
		sample_t     e;
		if (fifo_level < STORE_DEPTH) begin
			byte_fifo[wr_ptr] = b;
			wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
			fifo_level++;
		end
		blk_fill++;
		need_in = (set_in == 8'd0) ? 1 : ((set_in > 8'd128) ? 128 : set_in);
		if (blk_fill < need_in) begin
			return;
		end
		blk_fill = 0;
		need_out = (set_out > OUT_MAX) ? OUT_MAX : set_out;
		need_out = need_out & ~32'd1;
		if (need_out < 2) begin
			need_out = 2;
		end
		if (fifo_level < need_out) begin
			return;
		end
		nsamp = need_out / 2;
		for (int unsigned k = 0; k < nsamp; k++) begin
			lo = byte_fifo[rd_ptr];
			rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
			hi = byte_fifo[rd_ptr];
			rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
			fifo_level -= 2;
			if (!set_mute) begin
				e.smp = scale_sample({hi, lo}, set_gain);
				e.last = (k + 1 == nsamp);
				due_samples.push_back(e);
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic cfg_write(input logic [arvs_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			arvs_pkg::CFG_BLOCK_IN: set_in = val[7:0];
			arvs_pkg::CFG_BLOCK_OUT: set_out = val[7:0];
			arvs_pkg::CFG_GAIN: set_gain = val;
			arvs_pkg::CFG_MUTE: set_mute = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(input logic [7:0] bin, input logic [7:0] bout,
			input logic [15:0] g, input logic m);
		cfg_write(arvs_pkg::CFG_BLOCK_IN, {8'd0, bin});
		cfg_write(arvs_pkg::CFG_BLOCK_OUT, {8'd0, bout});
		cfg_write(arvs_pkg::CFG_GAIN, g);
		cfg_write(arvs_pkg::CFG_MUTE, {15'd0, m});
		@(posedge clk);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			pending_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// sender quiet, all samples back, then the block's own drain time
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
		while (due_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// input handshake: feeds the predictor
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			stash_byte(data_byte);
			in_took = 1'b1;
		end
	end

	// sender: bursts with random gaps
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			in_took = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				data_byte <= pending_bytes.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: long hold-off on request, otherwise a rotating stall pattern
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			case ((cycles >> 6) & 3)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (cycles[2:0] != 3'd5) && (cycles[2:0] != 3'd6);
			endcase
		end
	end

	// output checker
	always @(posedge clk) begin
		sample_t e;
		if (out_valid && out_ready) begin
			if (due_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample %0d last %0b", sample,
					last_sample));
			end else begin
				e = due_samples.pop_front();
				if (sample !== e.smp) begin
					report_mismatch($sformatf("sample %0d, want %0d", sample, e.smp));
				end
				if (last_sample !== e.last) begin
					report_mismatch($sformatf("last_sample %0b, want %0b", last_sample,
						e.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int          rnd_phases;
		logic [7:0]  bin;
		logic [7:0]  bout;
		logic [15:0] g;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rounding half away from zero at half gain
		set_all(8'd2, 8'd4, 16'd128, 1'b0);
		pending_bytes = '{8'h01, 8'h00, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'hFD, 8'hFF};
		wait_drained();

		// bypass gain, zero and tiny block sizes
		set_all(8'd0, 8'd1, 16'd0, 1'b0);
		pending_bytes = '{8'h00, 8'h80, 8'hFF, 8'h7F};
		wait_drained();

		// full gain saturation, input block larger than output block
		set_all(8'd4, 8'd2, 16'hFFFF, 1'b0);
		pending_bytes = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h01, 8'h00, 8'h00};
		wait_drained();

		// mute drops whole blocks
		set_all(8'd2, 8'd2, 16'd256, 1'b1);
		pending_bytes = '{8'h12, 8'h34, 8'h56, 8'h78};
		wait_drained();

		// oversize input blocks, FIFO overruns and drops
		set_all(8'd255, 8'd0, 16'($urandom_range(0, 65535)), 1'b0);
		queue_random(270);
		wait_drained();

		// output held off: block fills and stalls its input
		set_all(8'd2, 8'd16, 16'($urandom_range(1, 1023)), 1'b0);
		queue_random(80);
		hold_req = 1'b1;
		wait_drained();

		rnd_phases = 0;
		while (rnd_phases < RND_PHASES) begin
			case ($urandom_range(0, 9))
				0: bin = 8'd0;
				1: bin = 8'd128;
				2: bin = 8'($urandom_range(129, 255));
				3: bin = 8'd1;
				default: bin = 8'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 9))
				0: bout = 8'($urandom_range(0, 1));
				1: bout = 8'd128;
				2: bout = 8'($urandom_range(129, 255));
				default: bout = 8'($urandom_range(2, 32));
			endcase
			case ($urandom_range(0, 6))
				0: g = 16'd0;
				1: g = 16'hFFFF;
				2: g = 16'd256;
				3: g = 16'($urandom_range(0, 65535));
				default: g = 16'($urandom_range(1, 1023));
			endcase
			set_all(bin, bout, g, $urandom_range(0, 4) == 0);
			queue_random(15);
			wait_drained();
			rnd_phases++;
		end

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
